// ===== rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps

package bsc_pkg;

  // Cache geometry
  localparam int NumSet     = 32;
  localparam int Ways       = 4;
  localparam int BankCount  = 4;
  localparam int BlockWords = 32;
  localparam int AddrBits   = 32;

  // Address slicing, lowest field first
  localparam int OffBits  = $clog2(BlockWords);
  localparam int SetBits  = $clog2(NumSet);
  localparam int BankBits = $clog2(BankCount);
  localparam int TagBits  = AddrBits - OffBits - SetBits - BankBits;
  localparam int WayBits  = $clog2(Ways);

  // One row per bank and set
  localparam int Rows    = NumSet * BankCount;
  localparam int RowBits = $clog2(Rows);

  // Result packing
  localparam int OutBits   = 1 + BankBits + SetBits + WayBits + OffBits + TagBits + 1 + TagBits;
  localparam int OutTBits  = ((OutBits + 7) / 8) * 8;

  typedef logic [TagBits-1:0] tag_t;
  typedef logic [WayBits-1:0] way_t;
  typedef logic [RowBits-1:0] row_idx_t;

  typedef struct packed {
    logic [Ways-1:0]  valid;
    way_t [Ways-1:0]  rank;
  } row_state_t;

  typedef tag_t [Ways-1:0] row_tags_t;

  typedef struct packed {
    logic hit;
    way_t way;
    logic evicted;
    tag_t evicted_tag;
  } lookup_t;

  // State of a row that was never written: no valid way, rank equals way index
  function automatic row_state_t reset_row();
    row_state_t r;
    r.valid = '0;
    for (int w = 0; w < Ways; w++) begin
      r.rank[w] = way_t'(w);
    end
    return r;
  endfunction

endpackage

// ===== rtl/banked_set_assoc_cache_lru_core.sv =====
`timescale 1ns / 1ps

// Tag and LRU replacement engine of a banked 4-way set-associative cache.
// Input stream: one word address per transfer on s_axis. Each address is split
// into word offset, set, bank and tag; bank and set together pick one row of
// tags, valid bits and recency ranks.
// Output stream: one result per input transfer on m_axis, in order: hit flag,
// bank, set, way used, offset, tag, and the evicted tag when a miss replaced a
// valid line.
// Pipeline: a registered row read, then lookup and the result register.
// Throughput: one address per cycle, sustained while the receiver takes results;
// the single read and write port of the row memories is touched once per item,
// and a row written at the same edge it is read is forwarded from the write data.
// Reset: all lines read as invalid and ranks as the way index at once, through
// one valid flop per row; no clearing pass is needed.
// Stall: while the output holds an untaken result, one more item can sit in
// the lookup stage; after that s_axis_tready_o drops until the receiver takes
// the result.
module banked_set_assoc_cache_lru_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // address
  input  logic [bsc_pkg::AddrBits-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // hit, bank, set_index, way, word_offset, line_tag, evicted, evicted_tag
  output logic [bsc_pkg::OutTBits-1:0]  m_axis_tdata_o
);

  localparam int RowLo = bsc_pkg::OffBits;
  localparam int TagLo = bsc_pkg::OffBits + bsc_pkg::RowBits;

  // Lookup stage
  logic                                s1_valid_q;
  logic [bsc_pkg::OffBits-1:0]         s1_off_q;
  bsc_pkg::row_idx_t                   s1_row_q;
  bsc_pkg::tag_t                       s1_tag_q;

  // Result register
  logic                                m_valid_q;
  logic [bsc_pkg::OutTBits-1:0]        m_data_q;
  logic [bsc_pkg::OutTBits-1:0]        m_data_d;

  logic                                s1_adv;
  logic                                accept;

  bsc_pkg::row_state_t                 row_state;
  bsc_pkg::row_tags_t                  row_tags;
  bsc_pkg::row_state_t                 new_state;
  bsc_pkg::row_tags_t                  new_tags;
  bsc_pkg::lookup_t                    lk;

  // Advance the lookup stage when the result register is free or drains now
  assign s1_adv          = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  bsc_row_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_row_i   (s_axis_tdata_i[TagLo-1:RowLo]),
    .wr_en_i    (s1_adv),
    .wr_row_i   (s1_row_q),
    .wr_state_i (new_state),
    .wr_tags_i  (new_tags),
    .row_state_o(row_state),
    .row_tags_o (row_tags)
  );

  bsc_lookup u_lookup (
    .tag_i      (s1_tag_q),
    .row_state_i(row_state),
    .row_tags_i (row_tags),
    .lookup_o   (lk),
    .new_state_o(new_state),
    .new_tags_o (new_tags)
  );

  // Hold the address fields alongside the row read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_off_q <= s_axis_tdata_i[RowLo-1:0];
      s1_row_q <= s_axis_tdata_i[TagLo-1:RowLo];
      s1_tag_q <= s_axis_tdata_i[bsc_pkg::AddrBits-1:TagLo];
    end
  end

  // Row index is {bank, set}, so bank sits in its upper bits
  assign m_data_d = bsc_pkg::OutTBits'({lk.evicted_tag, lk.evicted, s1_tag_q, s1_off_q,
                                        lk.way, s1_row_q[bsc_pkg::SetBits-1:0],
                                        s1_row_q[bsc_pkg::RowBits-1:bsc_pkg::SetBits],
                                        lk.hit});

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= m_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Checks
  logic [bsc_pkg::Ways-1:0] front_vec;
  logic [bsc_pkg::Ways-1:0] back_vec;

  always_comb begin
    for (int w = 0; w < bsc_pkg::Ways; w++) begin
      front_vec[w] = (row_state.rank[w] == '0);
      back_vec[w]  = (row_state.rank[w] == bsc_pkg::way_t'(bsc_pkg::Ways - 1));
    end
  end

  // Ranks of the looked-up row stay a permutation, forwarded or not
  a_rank_perm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ($onehot(front_vec) && $onehot(back_vec)))
    else $error("recency ranks of the looked-up row are not a permutation");

  // An advancing item always lands in the result register
  a_adv_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> m_axis_tvalid_o)
    else $error("lookup advanced but no result is presented");

  // Two consecutive accesses to the same line: the second one hits
  a_fwd_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && $past(s1_adv) && ($past(s1_row_q) == s1_row_q) &&
     ($past(s1_tag_q) == s1_tag_q)) |-> lk.hit)
    else $error("line filled one cycle earlier did not hit");

  // A hit never reports an eviction
  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && lk.hit) |=> !m_axis_tdata_o[bsc_pkg::OutBits-bsc_pkg::TagBits-1])
    else $error("hit reported an evicted line");

endmodule

// ===== rtl/bsc_row_store.sv =====
`timescale 1ns / 1ps

module bsc_row_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  bsc_pkg::row_idx_t     rd_row_i,
  input  logic                  wr_en_i,
  input  bsc_pkg::row_idx_t     wr_row_i,
  input  bsc_pkg::row_state_t   wr_state_i,
  input  bsc_pkg::row_tags_t    wr_tags_i,
  output bsc_pkg::row_state_t   row_state_o,
  output bsc_pkg::row_tags_t    row_tags_o
);

  bsc_pkg::row_state_t state_mem [bsc_pkg::Rows];
  bsc_pkg::row_tags_t  tag_mem   [bsc_pkg::Rows];

  logic [bsc_pkg::Rows-1:0] row_vld_q;

  bsc_pkg::row_state_t st_rd_q;
  bsc_pkg::row_tags_t  tag_rd_q;
  logic                rv_rd_q;
  logic                byp_q;
  bsc_pkg::row_state_t byp_st_q;
  bsc_pkg::row_tags_t  byp_tags_q;

  // Memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      state_mem[wr_row_i] <= wr_state_i;
      tag_mem[wr_row_i]   <= wr_tags_i;
    end
    if (rd_en_i) begin
      st_rd_q  <= state_mem[rd_row_i];
      tag_rd_q <= tag_mem[rd_row_i];
    end
  end

  // Write data captured for a read of the row written at the same edge
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_st_q   <= wr_state_i;
      byp_tags_q <= wr_tags_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rv_rd_q   <= 1'b0;
      byp_q     <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rv_rd_q <= row_vld_q[rd_row_i];
        byp_q   <= wr_en_i && (wr_row_i == rd_row_i);
      end
      if (wr_en_i) begin
        row_vld_q[wr_row_i] <= 1'b1;
      end
    end
  end

  assign row_state_o = byp_q   ? byp_st_q :
                       rv_rd_q ? st_rd_q  : bsc_pkg::reset_row();
  assign row_tags_o  = byp_q   ? byp_tags_q : tag_rd_q;

endmodule

// ===== rtl/bsc_lookup.sv =====
`timescale 1ns / 1ps

module bsc_lookup (
  input  bsc_pkg::tag_t        tag_i,
  input  bsc_pkg::row_state_t  row_state_i,
  input  bsc_pkg::row_tags_t   row_tags_i,
  output bsc_pkg::lookup_t     lookup_o,
  output bsc_pkg::row_state_t  new_state_o,
  output bsc_pkg::row_tags_t   new_tags_o
);

  logic [bsc_pkg::Ways-1:0] hit_vec;
  logic                     any_hit;
  logic                     any_free;
  bsc_pkg::way_t            hit_way;
  bsc_pkg::way_t            free_way;
  bsc_pkg::way_t            lru_way;
  bsc_pkg::way_t            used;
  bsc_pkg::way_t            old_rank;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    any_free = 1'b0;
    for (int w = bsc_pkg::Ways - 1; w >= 0; w--) begin
      hit_vec[w] = row_state_i.valid[w] && (row_tags_i[w] == tag_i);
      if (hit_vec[w]) begin
        hit_way = bsc_pkg::way_t'(w);
      end
      if (!row_state_i.valid[w]) begin
        free_way = bsc_pkg::way_t'(w);
        any_free = 1'b1;
      end
    end
    any_hit = |hit_vec;

    // Oldest way: first way holding the highest rank
    lru_way = '0;
    for (int w = 1; w < bsc_pkg::Ways; w++) begin
      if (row_state_i.rank[w] > row_state_i.rank[lru_way]) begin
        lru_way = bsc_pkg::way_t'(w);
      end
    end

    used = any_hit ? hit_way : (any_free ? free_way : lru_way);

    lookup_o.hit         = any_hit;
    lookup_o.way         = used;
    lookup_o.evicted     = !any_hit && !any_free;
    lookup_o.evicted_tag = lookup_o.evicted ? row_tags_i[used] : '0;

    // Fill on a miss
    new_tags_o  = row_tags_i;
    new_state_o = row_state_i;
    if (!any_hit) begin
      new_tags_o[used]        = tag_i;
      new_state_o.valid[used] = 1'b1;
    end

    // Move the used way to the front, age the ways that were ahead of it
    old_rank = row_state_i.rank[used];
    for (int w = 0; w < bsc_pkg::Ways; w++) begin
      if (bsc_pkg::way_t'(w) == used) begin
        new_state_o.rank[w] = '0;
      end else if (row_state_i.rank[w] < old_rank) begin
        new_state_o.rank[w] = row_state_i.rank[w] + 1'b1;
      end else begin
        new_state_o.rank[w] = row_state_i.rank[w];
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 275;
  localparam int HoldCycles = 250;
  localparam int Lines      = bsc_pkg::Rows * bsc_pkg::Ways;

  // One lookup result, lowest field last so it lines up with the m_axis tdata packing
  typedef struct packed {
    bsc_pkg::tag_t                evicted_tag;
    logic                         evicted;
    bsc_pkg::tag_t                line_tag;
    logic [bsc_pkg::OffBits-1:0]  word_offset;
    bsc_pkg::way_t                way;
    logic [bsc_pkg::SetBits-1:0]  set_index;
    logic [bsc_pkg::BankBits-1:0] bank;
    logic                         hit;
  } access_result_t;

  // Mirror of the tag, valid and recency state; predicts one result per access
  class cache_scoreboard;
    bsc_pkg::tag_t  line_tag_mem [Lines];
    bit             line_valid   [Lines];
    bsc_pkg::way_t  line_rank    [Lines];
    access_result_t expected_lookups [$];
    int             errors;

    function new();
      errors = 0;
      for (int i = 0; i < Lines; i++) begin
        line_tag_mem[i] = '0;
        line_valid[i]   = 1'b0;
        line_rank[i]    = bsc_pkg::way_t'(i % bsc_pkg::Ways);
      end
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    // Predict the lookup for an accepted address and update the mirror
    function void note_access(input logic [bsc_pkg::AddrBits-1:0] a);
      access_result_t r;
      int             base;
      int             used;
      bit             found;
      bsc_pkg::way_t  old_rank;
      r = '0;
      r.word_offset = a[bsc_pkg::OffBits-1:0];
      r.set_index   = a[bsc_pkg::OffBits +: bsc_pkg::SetBits];
      r.bank        = a[bsc_pkg::OffBits+bsc_pkg::SetBits +: bsc_pkg::BankBits];
      r.line_tag    = a[bsc_pkg::AddrBits-1 -: bsc_pkg::TagBits];
      base  = (int'(r.bank) * bsc_pkg::NumSet + int'(r.set_index)) * bsc_pkg::Ways;
      used  = 0;
      found = 1'b0;
      for (int w = 0; w < bsc_pkg::Ways; w++) begin
        if (!found && line_valid[base+w] && line_tag_mem[base+w] == r.line_tag) begin
          found = 1'b1;
          used  = w;
        end
      end
      r.hit = found;
      if (!found) begin
        // lowest invalid way first
        for (int w = 0; w < bsc_pkg::Ways; w++) begin
          if (!found && !line_valid[base+w]) begin
            found = 1'b1;
            used  = w;
          end
        end
        // set full: replace the oldest way, first one on a tie
        if (!found) begin
          used = 0;
          for (int w = 1; w < bsc_pkg::Ways; w++) begin
            if (line_rank[base+w] > line_rank[base+used]) used = w;
          end
          r.evicted     = 1'b1;
          r.evicted_tag = line_tag_mem[base+used];
        end
        line_tag_mem[base+used] = r.line_tag;
        line_valid[base+used]   = 1'b1;
      end
      old_rank = line_rank[base+used];
      for (int w = 0; w < bsc_pkg::Ways; w++) begin
        if (line_rank[base+w] < old_rank) line_rank[base+w] = line_rank[base+w] + 1'b1;
      end
      line_rank[base+used] = '0;
      r.way = bsc_pkg::way_t'(used);
      expected_lookups.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(input logic [bsc_pkg::OutTBits-1:0] raw);
      access_result_t got;
      access_result_t want;
      got = access_result_t'(raw);
      if (expected_lookups.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with nothing expected: %h", raw);
        return;
      end
      want = expected_lookups.pop_front();
      if (got.hit !== want.hit || got.bank !== want.bank || got.set_index !== want.set_index ||
          got.way !== want.way || got.word_offset !== want.word_offset ||
          got.line_tag !== want.line_tag || got.evicted !== want.evicted ||
          got.evicted_tag !== want.evicted_tag) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: exp hit=%0d bank=%0d set=%0d way=%0d off=%0d tag=%h ev=%0d evtag=%h",
                   want.hit, want.bank, want.set_index, want.way, want.word_offset,
                   want.line_tag, want.evicted, want.evicted_tag);
          $display("       got hit=%0d bank=%0d set=%0d way=%0d off=%0d tag=%h ev=%0d evtag=%h",
                   got.hit, got.bank, got.set_index, got.way, got.word_offset,
                   got.line_tag, got.evicted, got.evicted_tag);
        end
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_valid;
  logic                         s_ready;
  logic [bsc_pkg::AddrBits-1:0] s_data;
  logic                         m_valid;
  logic                         m_ready;
  logic [bsc_pkg::OutTBits-1:0] m_data;

  cache_scoreboard sb = new();

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  int cycles    = 0;

  banked_set_assoc_cache_lru_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: stop a hung run
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [bsc_pkg::AddrBits-1:0] make_addr(input bsc_pkg::tag_t tag,
                                                             input int bank,
                                                             input int set, input int off);
    return {tag, bsc_pkg::BankBits'(bank), bsc_pkg::SetBits'(set),
            bsc_pkg::OffBits'(off)};
  endfunction

  // Offer one address, idling first at random; hold tvalid until the transfer
  task automatic send_access(input logic [bsc_pkg::AddrBits-1:0] a);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= a;
    do @(posedge clk_i); while (!s_ready);
    sb.note_access(a);
  endtask

  // Receiver: check each result transfer, stall at random, or hold off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_valid && m_ready) sb.check_result(m_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int            idle_tab  [4];
    int            stall_tab [4];
    bsc_pkg::tag_t tag;
    int            bank;
    int            set;
    idle_tab  = '{0, 68, 0, 33};
    stall_tab = '{0, 0, 68, 33};
    rst_ni  <= 1'b0;
    s_valid <= 1'b0;
    s_data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: cold misses, hits, lowest invalid way, LRU victims, extremes
    send_access(make_addr(20'h00000, 0, 0, 0));
    send_access(make_addr(20'h00000, 0, 0, 31));
    send_access(32'hFFFF_FFFF);
    send_access(make_addr(20'h00001, 0, 0, 5));
    send_access(make_addr(20'h00002, 0, 0, 6));
    send_access(make_addr(20'h00003, 0, 0, 7));
    send_access(make_addr(20'h00000, 0, 0, 1));
    send_access(make_addr(20'h00004, 0, 0, 2));
    send_access(make_addr(20'hFFFFF, 0, 0, 3));
    send_access(make_addr(20'h00003, 0, 0, 4));
    send_access(make_addr(20'h00001, 0, 0, 0));
    send_access(make_addr(20'hFFFFF, 3, 31, 0));
    send_access(make_addr(20'h00000, 3, 31, 0));
    send_access(make_addr(20'h55555, 2, 10, 21));
    send_access(make_addr(20'hAAAAA, 1, 21, 10));
    send_access(make_addr(20'h55555, 2, 10, 0));
    send_access(make_addr(20'h00000, 1, 0, 0));
    send_access(make_addr(20'h00000, 0, 0, 0));

    // Random: mostly a few hot rows with a small tag pool, so hits and
    // evictions both happen; the rest fully random addresses
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_tab[phase];
      stall_pct = stall_tab[phase];
      // long receiver hold-off while items keep coming: fill the pipe
      if (phase == 0) hold_req = 1'b1;
      repeat (PhaseItems) begin
        if ($urandom_range(99) < 80) begin
          bank = $urandom_range(bsc_pkg::BankCount - 1);
          case ($urandom_range(3))
            0:       set = 0;
            1:       set = 31;
            2:       set = 5;
            default: set = 17;
          endcase
          tag = bsc_pkg::tag_t'($urandom_range(4));
          if ($urandom_range(1)) tag = ~tag;
          send_access(make_addr(tag, bank, set, $urandom_range(bsc_pkg::BlockWords - 1)));
        end else begin
          send_access($urandom);
        end
      end
    end
    s_valid <= 1'b0;

    // Drain, then give stray results time to show up
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
